@@ hw/rtl/lgts_pkg.sv @@
package lgts_pkg;

   // Default sizes handed to the top level
   localparam int TOPICS_DEF     = 64;
   localparam int DOCS_DEF       = 1024;
   localparam int WORDS_DEF      = 4096;
   localparam int COUNT_BITS_DEF = 24;

   // Fixed datapath widths
   localparam int FRAC_BITS  = 16;
   localparam int W_BITS     = 48;
   localparam int U_BITS     = 53;
   localparam int SUM_BITS   = 55;
   localparam int KCNT_BITS  = 7;
   localparam int V_BITS     = 13;
   localparam int BSUM_BITS  = 45;
   localparam int DEN_BITS   = 49;
   localparam int PROD_BITS  = 128;
   localparam int OPB_BITS   = 64;
   localparam int TOT_BITS   = 32;

   localparam logic [W_BITS-1:0] WMAX = '1;

   // Hash constants
   localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

   // Register reset values
   localparam logic [31:0]        ALPHA_RST = 32'd6554;
   localparam logic [31:0]        BETA_RST  = 32'd6554;
   localparam logic [6:0]         NTOP_RST  = 7'd2;
   localparam logic [V_BITS-1:0]  NWORD_RST = 13'd4096;
   localparam logic [63:0]        SEED_RST  = 64'd1;

   typedef enum logic [2:0] {
      CSR_ALPHA  = 3'd0,
      CSR_BETA   = 3'd1,
      CSR_NTOP   = 3'd2,
      CSR_NWORD  = 3'd3,
      CSR_SEED   = 3'd4,
      CSR_MODE   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_SAMPLE = 2'd2
   } kind_type;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic clear;
      logic we;
   } cs_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLR_WAIT,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_HASH_GO,
      ST_HASH_IT,
      ST_HASH_M1,
      ST_HASH_M2,
      ST_W_RD,
      ST_W_OPS,
      ST_W_MUL,
      ST_W_DIV,
      ST_U_GO,
      ST_U_MUL,
      ST_S_RD,
      ST_S_CMP,
      ST_RESP
   } state_type;

endpackage

@@ hw/rtl/lgts_alu.sv @@
module lgts_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lgts_pkg::alu_ctl_type                ctl,
   input  logic [lgts_pkg::PROD_BITS-1:0]       a_op,
   input  logic [lgts_pkg::OPB_BITS-1:0]        b_op,
   output logic                                 busy,
   output logic [lgts_pkg::PROD_BITS-1:0]       result
);

   logic                                 busy_ff, busy_in;
   lgts_pkg::alu_op_type                 op_ff, op_in;
   logic [lgts_pkg::PROD_BITS-1:0]       mcand_ff, mcand_in;
   logic [lgts_pkg::OPB_BITS-1:0]        mplier_ff, mplier_in;
   logic [lgts_pkg::PROD_BITS-1:0]       acc_ff, acc_in;
   logic [lgts_pkg::OPB_BITS-1:0]        rem_ff, rem_in;
   logic [lgts_pkg::OPB_BITS-1:0]        den_ff, den_in;
   logic [5:0]                           cnt_ff, cnt_in;
   logic [lgts_pkg::OPB_BITS-1:0]        rem_shift;
   logic                                 qbit;

   assign busy   = busy_ff;
   assign result = acc_ff;

   // Next partial remainder for one restoring divide step
   assign rem_shift = {rem_ff[lgts_pkg::OPB_BITS-2:0], mcand_ff[lgts_pkg::W_BITS-1]};
   assign qbit      = (rem_shift >= den_ff);

   always_comb begin
      busy_in   = busy_ff;
      op_in     = op_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      if (ctl.start) begin
         op_in = ctl.op;
         if (ctl.op == lgts_pkg::ALU_MUL) begin
            // Load shift-add multiply
            mcand_in  = a_op;
            mplier_in = b_op;
            acc_in    = '0;
            busy_in   = 1'b1;
         end else begin
            // Load divide; zero divisor and quotient overflow finish at once
            den_in   = b_op;
            rem_in   = a_op[lgts_pkg::OPB_BITS+lgts_pkg::W_BITS-1:lgts_pkg::W_BITS];
            mcand_in = {{(lgts_pkg::PROD_BITS-lgts_pkg::W_BITS){1'b0}},
                        a_op[lgts_pkg::W_BITS-1:0]};
            cnt_in   = 6'(lgts_pkg::W_BITS - 1);
            if (b_op == '0) begin
               acc_in  = '0;
               busy_in = 1'b0;
            end else if (a_op[lgts_pkg::PROD_BITS-1:lgts_pkg::W_BITS] >=
                         (lgts_pkg::PROD_BITS-lgts_pkg::W_BITS)'(b_op)) begin
               acc_in  = lgts_pkg::PROD_BITS'(lgts_pkg::WMAX);
               busy_in = 1'b0;
            end else begin
               acc_in  = '0;
               busy_in = 1'b1;
            end
         end
      end else if (busy_ff) begin
         if (op_ff == lgts_pkg::ALU_MUL) begin
            // Add one multiplier bit a cycle, stop when none remain
            if (mplier_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               if (mplier_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[lgts_pkg::PROD_BITS-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[lgts_pkg::OPB_BITS-1:1]};
            end
         end else begin
            // One quotient bit a cycle
            rem_in   = qbit ? (rem_shift - den_ff) : rem_shift;
            acc_in   = {acc_ff[lgts_pkg::PROD_BITS-2:0], qbit};
            mcand_in = {mcand_ff[lgts_pkg::PROD_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= lgts_pkg::ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      cnt_ff    <= cnt_in;
   end

endmodule

@@ hw/rtl/lgts_count_store.sv @@
module lgts_count_store #(
   parameter int TOPICS     = lgts_pkg::TOPICS_DEF,
   parameter int DOCS       = lgts_pkg::DOCS_DEF,
   parameter int WORDS      = lgts_pkg::WORDS_DEF,
   parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF,
   localparam int TB  = $clog2(TOPICS),
   localparam int DAW = $clog2(DOCS * TOPICS),
   localparam int WAW = $clog2(WORDS * TOPICS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lgts_pkg::cs_ctl_type              ctl,
   input  logic [DAW-1:0]                    doc_addr,
   input  logic [WAW-1:0]                    word_addr,
   input  logic [TB-1:0]                     topic,
   input  logic [COUNT_BITS-1:0]             doc_wd,
   input  logic [COUNT_BITS-1:0]             word_wd,
   input  logic [lgts_pkg::TOT_BITS-1:0]     tot_wd,
   output logic [COUNT_BITS-1:0]             doc_rd,
   output logic [COUNT_BITS-1:0]             word_rd,
   output logic [lgts_pkg::TOT_BITS-1:0]     tot_rd,
   output logic                              busy
);

   localparam int DDEPTH = DOCS * TOPICS;
   localparam int WDEPTH = WORDS * TOPICS;
   localparam int SDEPTH = (DDEPTH > WDEPTH) ? DDEPTH : WDEPTH;
   localparam int SB     = $clog2(SDEPTH);

   logic [COUNT_BITS-1:0]            doc_mem  [DDEPTH];
   logic [COUNT_BITS-1:0]            word_mem [WDEPTH];
   logic [lgts_pkg::TOT_BITS-1:0]    tot_mem  [TOPICS];

   logic                             busy_ff, busy_in;
   logic [SB-1:0]                    idx_ff, idx_in;
   logic                             doc_we, word_we, tot_we;
   logic [DAW-1:0]                   doc_wa;
   logic [WAW-1:0]                   word_wa;
   logic [TB-1:0]                    tot_wa;
   logic [COUNT_BITS-1:0]            doc_rd_ff, word_rd_ff;
   logic [lgts_pkg::TOT_BITS-1:0]    tot_rd_ff;

   assign busy    = busy_ff;
   assign doc_rd  = doc_rd_ff;
   assign word_rd = word_rd_ff;
   assign tot_rd  = tot_rd_ff;

   // Sweep zeros through every entry after reset and on clear
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (ctl.clear) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff) begin
         if (idx_ff == SB'(SDEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + SB'(1);
         end
      end
   end

   // Pick write port between sweep and host update
   always_comb begin
      if (busy_ff) begin
         doc_we  = (32'(idx_ff) < DDEPTH);
         word_we = (32'(idx_ff) < WDEPTH);
         tot_we  = (32'(idx_ff) < TOPICS);
         doc_wa  = DAW'(idx_ff);
         word_wa = WAW'(idx_ff);
         tot_wa  = TB'(idx_ff);
      end else begin
         doc_we  = ctl.we;
         word_we = ctl.we;
         tot_we  = ctl.we;
         doc_wa  = doc_addr;
         word_wa = word_addr;
         tot_wa  = topic;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (doc_we) begin
         doc_mem[doc_wa] <= busy_ff ? '0 : doc_wd;
      end
      doc_rd_ff <= doc_mem[doc_addr];
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_wa] <= busy_ff ? '0 : word_wd;
      end
      word_rd_ff <= word_mem[word_addr];
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_wa] <= busy_ff ? '0 : tot_wd;
      end
      tot_rd_ff <= tot_mem[topic];
   end

endmodule

@@ hw/rtl/lda_gibbs_token_sampler.sv @@
// Topic sampler for collapsed Gibbs LDA with on-chip count tables.
// req channel: one beat per command. tuser carries the kind (clear all
// counts, add a token's topic, sample a token); tdata carries the token.
// rsp channel: exactly one beat per request with the sampled topic and the
// sampled / range_error flags. csr channel: register writes, always ready;
// write only while no request is in flight.
// An add reads the doc, word and total counts, then writes them back
// incremented. A sample runs the hash through three serial multiplies,
// then per topic one serial multiply and one 48-step divide, then a serial
// u*sum multiply and a search that reads and compares one topic at a time.
// All of it shares one shift-add/subtract unit, so one item is in flight
// at a time and req_tready stays low until its result is registered.
// Clear sweeps the count memories one entry a cycle: max(DOCS, WORDS) *
// TOPICS entries (262144 with defaults). The same sweep runs after reset,
// while req_tready is low. A stalled rsp holds its beat; the next request
// is still taken and its result waits behind the held beat.
module lda_gibbs_token_sampler #(
   parameter int TOPICS     = lgts_pkg::TOPICS_DEF,
   parameter int DOCS       = lgts_pkg::DOCS_DEF,
   parameter int WORDS      = lgts_pkg::WORDS_DEF,
   parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // doc_index[9:0], word_index[21:10], token_topic[27:22], token_index[58:28],
   // iteration[89:59], zero pad[95:90]
   input  logic [95:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drawn_topic[5:0], zero pad[7:6]
   output logic [7:0]  rsp_tdata,
   // sampled[0], range_error[1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int TB  = $clog2(TOPICS);
   localparam int DAW = $clog2(DOCS * TOPICS);
   localparam int WAW = $clog2(WORDS * TOPICS);
   localparam int DTW = COUNT_BITS + lgts_pkg::FRAC_BITS + 1;
   localparam int KW  = lgts_pkg::KCNT_BITS;

   // Configuration registers
   logic [31:0]                   alpha_ff, beta_ff;
   logic [6:0]                    ntop_ff;
   logic [lgts_pkg::V_BITS-1:0]   nword_ff;
   logic [63:0]                   seed_ff;
   logic                          mode_ff;

   // Sequencer registers
   lgts_pkg::state_type           state_ff, state_in;
   logic [9:0]                    d_ff, d_in;
   logic [11:0]                   w_ff, w_in;
   logic [5:0]                    t_ff, t_in;
   logic [30:0]                   tok_ff, tok_in;
   logic [30:0]                   it_ff, it_in;
   logic [KW-1:0]                 k_ff, k_in;
   logic [lgts_pkg::BSUM_BITS-1:0] bsum_ff, bsum_in;
   logic [lgts_pkg::DEN_BITS-1:0] den_ff, den_in;
   logic [lgts_pkg::U_BITS-1:0]   u_ff, u_in;
   logic [lgts_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [lgts_pkg::SUM_BITS-1:0] acc_ff, acc_in;
   logic [5:0]                    res_topic_ff, res_topic_in;
   logic                          res_smp_ff, res_smp_in;
   logic                          res_err_ff, res_err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [5:0]                    rsp_topic_ff, rsp_topic_in;
   logic                          rsp_smp_ff, rsp_smp_in;
   logic                          rsp_err_ff, rsp_err_in;

   // Weight memory
   logic [lgts_pkg::W_BITS-1:0]   wmem [TOPICS];
   logic [lgts_pkg::W_BITS-1:0]   wrd_ff;
   logic                          wmem_we;

   // Unit hookups
   lgts_pkg::alu_ctl_type         alu_ctl;
   logic [lgts_pkg::PROD_BITS-1:0] alu_a, alu_res;
   logic [lgts_pkg::OPB_BITS-1:0] alu_b;
   logic                          alu_busy;
   lgts_pkg::cs_ctl_type          cs_ctl;
   logic                          cs_busy;
   logic [KW-1:0]                 topic_sel;
   logic [DAW-1:0]                doc_addr;
   logic [WAW-1:0]                word_addr;
   logic [COUNT_BITS-1:0]         cd_rd, cw_rd, cd_inc, cw_inc, cd, cw;
   logic [lgts_pkg::TOT_BITS-1:0] ct_rd, ct_inc, ct;

   // Combinational helpers
   logic [9:0]                    f_doc;
   logic [11:0]                   f_word;
   logic [5:0]                    f_topic;
   logic [30:0]                   f_tok, f_it;
   logic [KW-1:0]                 k_val;
   logic [lgts_pkg::V_BITS-1:0]   v_val;
   logic                          bad_now, accept, old_hit;
   logic [63:0]                   phase_c, hx0, hx1, hy, hz;
   logic [DTW-1:0]                dt, wt;
   logic [lgts_pkg::DEN_BITS-1:0] den_now;
   logic [59:0]                   uk;
   logic [KW-1:0]                 uk_top;
   logic [lgts_pkg::SUM_BITS-1:0] acc_next;
   logic                          k_last;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == lgts_pkg::ST_IDLE) && !cs_busy;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_topic_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_smp_ff};

   // Unpack request beat
   assign f_doc   = req_tdata[9:0];
   assign f_word  = req_tdata[21:10];
   assign f_topic = req_tdata[27:22];
   assign f_tok   = req_tdata[58:28];
   assign f_it    = req_tdata[89:59];

   // Clamp topic count and vocabulary size
   always_comb begin
      if (ntop_ff < 7'd2) begin
         k_val = KW'(2);
      end else if (32'(ntop_ff) > TOPICS) begin
         k_val = KW'(TOPICS);
      end else begin
         k_val = ntop_ff;
      end
      if (nword_ff == '0) begin
         v_val = lgts_pkg::V_BITS'(1);
      end else if (32'(nword_ff) > WORDS) begin
         v_val = lgts_pkg::V_BITS'(WORDS);
      end else begin
         v_val = nword_ff;
      end
   end

   assign bad_now = (32'(f_doc) >= DOCS) || (lgts_pkg::V_BITS'(f_word) >= v_val) ||
                    (KW'(f_topic) >= k_val);

   // Count table addressing
   assign doc_addr  = DAW'(32'(d_ff) * 32'(TOPICS) + 32'(topic_sel));
   assign word_addr = WAW'(32'(w_ff) * 32'(TOPICS) + 32'(topic_sel));

   // Saturating increments for add
   assign cd_inc = (cd_rd == '1) ? cd_rd : cd_rd + COUNT_BITS'(1);
   assign cw_inc = (cw_rd == '1) ? cw_rd : cw_rd + COUNT_BITS'(1);
   assign ct_inc = (ct_rd == '1) ? ct_rd : ct_rd + 32'd1;

   // Drop the token's own topic from the counts (in mode 1 from the doc count only)
   assign old_hit = (k_ff == KW'(t_ff));
   assign cd = (old_hit && cd_rd != '0) ? cd_rd - COUNT_BITS'(1) : cd_rd;
   assign cw = (old_hit && !mode_ff && cw_rd != '0) ? cw_rd - COUNT_BITS'(1) : cw_rd;
   assign ct = (old_hit && !mode_ff && ct_rd != '0) ? ct_rd - 32'd1 : ct_rd;

   // Fixed-point weight operands
   assign dt = {1'b0, cd, {lgts_pkg::FRAC_BITS{1'b0}}} + DTW'(alpha_ff);
   assign wt = {1'b0, cw, {lgts_pkg::FRAC_BITS{1'b0}}} + DTW'(beta_ff);
   assign den_now = lgts_pkg::DEN_BITS'({ct, {lgts_pkg::FRAC_BITS{1'b0}}}) +
                    lgts_pkg::DEN_BITS'(bsum_ff);

   // Hash stages around the shared multiplier
   assign phase_c = mode_ff ? {lgts_pkg::MIX_C1[62:0], 1'b0} : lgts_pkg::MIX_C1;
   assign hx0 = (seed_ff ^ phase_c ^ alu_res[63:0] ^ 64'(tok_ff)) + lgts_pkg::GOLDEN;
   assign hx1 = hx0 ^ (hx0 >> 30);
   assign hy  = alu_res[63:0] ^ (alu_res[63:0] >> 27);
   assign hz  = alu_res[63:0] ^ (alu_res[63:0] >> 31);

   // Fallback draw when all weights are zero
   assign uk     = 60'(u_ff) * 60'(k_val);
   assign uk_top = uk[59:53];

   assign acc_next = acc_ff + lgts_pkg::SUM_BITS'(wrd_ff);
   assign k_last   = (k_ff == k_val - KW'(1));

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      w_in         = w_ff;
      t_in         = t_ff;
      tok_in       = tok_ff;
      it_in        = it_ff;
      k_in         = k_ff;
      bsum_in      = bsum_ff;
      den_in       = den_ff;
      u_in         = u_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      res_topic_in = res_topic_ff;
      res_smp_in   = res_smp_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_topic_in = rsp_topic_ff;
      rsp_smp_in   = rsp_smp_ff;
      rsp_err_in   = rsp_err_ff;
      alu_ctl      = '{start: 1'b0, op: lgts_pkg::ALU_MUL};
      alu_a        = '0;
      alu_b        = '0;
      cs_ctl       = '{clear: 1'b0, we: 1'b0};
      topic_sel    = k_ff;
      wmem_we      = 1'b0;

      case (state_ff)
         lgts_pkg::ST_IDLE: begin
            if (accept) begin
               d_in         = f_doc;
               w_in         = f_word;
               t_in         = f_topic;
               tok_in       = f_tok;
               it_in        = f_it;
               k_in         = '0;
               sum_in       = '0;
               bsum_in      = lgts_pkg::BSUM_BITS'(v_val) *
                              lgts_pkg::BSUM_BITS'(beta_ff);
               res_topic_in = '0;
               res_smp_in   = 1'b0;
               res_err_in   = 1'b0;
               case (req_tuser)
                  lgts_pkg::KIND_CLEAR: begin
                     cs_ctl.clear = 1'b1;
                     state_in     = lgts_pkg::ST_CLR_WAIT;
                  end
                  lgts_pkg::KIND_ADD: begin
                     res_err_in = bad_now;
                     state_in   = bad_now ? lgts_pkg::ST_RESP : lgts_pkg::ST_ADD_RD;
                  end
                  lgts_pkg::KIND_SAMPLE: begin
                     res_smp_in = 1'b1;
                     res_err_in = bad_now;
                     state_in   = bad_now ? lgts_pkg::ST_RESP : lgts_pkg::ST_HASH_GO;
                  end
                  default: begin
                     state_in = lgts_pkg::ST_RESP;
                  end
               endcase
            end
         end
         lgts_pkg::ST_CLR_WAIT: begin
            if (!cs_busy) begin
               state_in = lgts_pkg::ST_RESP;
            end
         end
         lgts_pkg::ST_ADD_RD: begin
            topic_sel = KW'(t_ff);
            state_in  = lgts_pkg::ST_ADD_WR;
         end
         lgts_pkg::ST_ADD_WR: begin
            topic_sel = KW'(t_ff);
            cs_ctl.we = 1'b1;
            state_in  = lgts_pkg::ST_RESP;
         end
         lgts_pkg::ST_HASH_GO: begin
            alu_ctl.start = 1'b1;
            alu_a         = lgts_pkg::PROD_BITS'(lgts_pkg::MIX_C2);
            alu_b         = 64'(it_ff);
            state_in      = lgts_pkg::ST_HASH_IT;
         end
         lgts_pkg::ST_HASH_IT: begin
            if (!alu_busy) begin
               alu_ctl.start = 1'b1;
               alu_a         = lgts_pkg::PROD_BITS'(hx1);
               alu_b         = lgts_pkg::MIX_C1;
               state_in      = lgts_pkg::ST_HASH_M1;
            end
         end
         lgts_pkg::ST_HASH_M1: begin
            if (!alu_busy) begin
               alu_ctl.start = 1'b1;
               alu_a         = lgts_pkg::PROD_BITS'(hy);
               alu_b         = lgts_pkg::MIX_C2;
               state_in      = lgts_pkg::ST_HASH_M2;
            end
         end
         lgts_pkg::ST_HASH_M2: begin
            if (!alu_busy) begin
               u_in     = hz[63:11];
               k_in     = '0;
               state_in = lgts_pkg::ST_W_RD;
            end
         end
         lgts_pkg::ST_W_RD: begin
            state_in = lgts_pkg::ST_W_OPS;
         end
         lgts_pkg::ST_W_OPS: begin
            den_in        = den_now;
            alu_ctl.start = 1'b1;
            alu_a         = lgts_pkg::PROD_BITS'(dt);
            alu_b         = lgts_pkg::OPB_BITS'(wt);
            state_in      = lgts_pkg::ST_W_MUL;
         end
         lgts_pkg::ST_W_MUL: begin
            if (!alu_busy) begin
               alu_ctl.start = 1'b1;
               alu_ctl.op    = lgts_pkg::ALU_DIV;
               alu_a         = alu_res;
               alu_b         = lgts_pkg::OPB_BITS'(den_ff);
               state_in      = lgts_pkg::ST_W_DIV;
            end
         end
         lgts_pkg::ST_W_DIV: begin
            if (!alu_busy) begin
               wmem_we = 1'b1;
               sum_in  = sum_ff + lgts_pkg::SUM_BITS'(alu_res[lgts_pkg::W_BITS-1:0]);
               if (k_last) begin
                  state_in = lgts_pkg::ST_U_GO;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = lgts_pkg::ST_W_RD;
               end
            end
         end
         lgts_pkg::ST_U_GO: begin
            k_in   = '0;
            acc_in = '0;
            if (sum_ff == '0) begin
               res_topic_in = (uk_top >= k_val) ? 6'(k_val - KW'(1)) : 6'(uk_top);
               state_in     = lgts_pkg::ST_RESP;
            end else begin
               alu_ctl.start = 1'b1;
               alu_a         = lgts_pkg::PROD_BITS'(sum_ff);
               alu_b         = lgts_pkg::OPB_BITS'(u_ff);
               state_in      = lgts_pkg::ST_U_MUL;
            end
         end
         lgts_pkg::ST_U_MUL: begin
            if (!alu_busy) begin
               state_in = lgts_pkg::ST_S_RD;
            end
         end
         lgts_pkg::ST_S_RD: begin
            state_in = lgts_pkg::ST_S_CMP;
         end
         lgts_pkg::ST_S_CMP: begin
            // Stop at the first topic whose running sum reaches u*sum
            if (alu_res[107:0] <= {acc_next, {lgts_pkg::U_BITS{1'b0}}}) begin
               res_topic_in = 6'(k_ff);
               state_in     = lgts_pkg::ST_RESP;
            end else if (k_last) begin
               res_topic_in = 6'(k_ff);
               state_in     = lgts_pkg::ST_RESP;
            end else begin
               acc_in   = acc_next;
               k_in     = k_ff + KW'(1);
               state_in = lgts_pkg::ST_S_RD;
            end
         end
         lgts_pkg::ST_RESP: begin
            // Load the output beat once the previous one is gone
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_topic_in = res_topic_ff;
               rsp_smp_in   = res_smp_ff;
               rsp_err_in   = res_err_ff;
               state_in     = lgts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lgts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff         <= d_in;
      w_ff         <= w_in;
      t_ff         <= t_in;
      tok_ff       <= tok_in;
      it_ff        <= it_in;
      k_ff         <= k_in;
      bsum_ff      <= bsum_in;
      den_ff       <= den_in;
      u_ff         <= u_in;
      sum_ff       <= sum_in;
      acc_ff       <= acc_in;
      res_topic_ff <= res_topic_in;
      res_smp_ff   <= res_smp_in;
      res_err_ff   <= res_err_in;
      rsp_topic_ff <= rsp_topic_in;
      rsp_smp_ff   <= rsp_smp_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= lgts_pkg::ALPHA_RST;
         beta_ff  <= lgts_pkg::BETA_RST;
         ntop_ff  <= lgts_pkg::NTOP_RST;
         nword_ff <= lgts_pkg::NWORD_RST;
         seed_ff  <= lgts_pkg::SEED_RST;
         mode_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            lgts_pkg::CSR_ALPHA: alpha_ff <= csr_data[31:0];
            lgts_pkg::CSR_BETA:  beta_ff  <= csr_data[31:0];
            lgts_pkg::CSR_NTOP:  ntop_ff  <= csr_data[6:0];
            lgts_pkg::CSR_NWORD: nword_ff <= csr_data[12:0];
            lgts_pkg::CSR_SEED:  seed_ff  <= csr_data;
            lgts_pkg::CSR_MODE:  mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Per-topic weights for the search pass
   always_ff @(posedge clock) begin
      if (wmem_we) begin
         wmem[TB'(k_ff)] <= alu_res[lgts_pkg::W_BITS-1:0];
      end
      wrd_ff <= wmem[TB'(k_ff)];
   end

   lgts_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a_op   (alu_a),
      .b_op   (alu_b),
      .busy   (alu_busy),
      .result (alu_res)
   );

   lgts_count_store #(
      .TOPICS     (TOPICS),
      .DOCS       (DOCS),
      .WORDS      (WORDS),
      .COUNT_BITS (COUNT_BITS)
   ) u_count_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cs_ctl),
      .doc_addr  (doc_addr),
      .word_addr (word_addr),
      .topic     (TB'(topic_sel)),
      .doc_wd    (cd_inc),
      .word_wd   (cw_inc),
      .tot_wd    (ct_inc),
      .doc_rd    (cd_rd),
      .word_rd   (cw_rd),
      .tot_rd    (ct_rd),
      .busy      (cs_busy)
   );

endmodule
